// File: sv/dlfa_pkg.sv
`default_nettype none
package dlfa_pkg;

   localparam int NEURONS  = 64;
   localparam int FRAC     = 12;
   localparam int SUM_W    = 40;
   localparam int Z_W      = 30;
   localparam int U_W      = 31;
   localparam int NUM_W    = 44;
   localparam int DEN_W    = 48;
   localparam int R_W      = 45;
   localparam int TERMS    = 12;

   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [30:0] LN2_Q30   = 31'd744261118;
   localparam logic [30:0] EXP_LIMIT = 31'(32 << FRAC);

   typedef enum logic [1:0] {
      MODE_WEIGHT = 2'd0,
      MODE_BIAS   = 2'd1,
      MODE_ACT    = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_IDENTITY = 3'd0,
      KIND_SIGMOID  = 3'd1,
      KIND_RELU     = 3'd2,
      KIND_TANH     = 3'd3,
      KIND_SOFTMAX  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_INPUT_COUNT  = 2'd0,
      CSR_NEURON_COUNT = 2'd1,
      CSR_ACT_KIND     = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      PASS_MAX = 2'd0,
      PASS_SUM = 2'd1,
      PASS_OUT = 2'd2
   } pass_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAC, ST_BIAS, ST_ZCALC, ST_ACT, ST_EXP0, ST_EXP1, ST_TERM,
      ST_TSTART, ST_TWAIT, ST_EXPEND, ST_POST, ST_AWAIT, ST_RESULT, ST_CLEAR
   } state_type;

   function automatic logic [6:0] eff_count(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (v == 7'd0) r = 7'd1;
      else if (v > 7'(NEURONS)) r = 7'(NEURONS);
      return r;
   endfunction

   // ceil(2^34 / i): exact floor division of a 30-bit term by i
   function automatic logic [33:0] term_recip(input logic [3:0] i);
      logic [33:0] r;
      case (i)
         4'd2:    r = 34'd8589934592;
         4'd3:    r = 34'd5726623062;
         4'd4:    r = 34'd4294967296;
         4'd5:    r = 34'd3435973837;
         4'd6:    r = 34'd2863311531;
         4'd7:    r = 34'd2454267027;
         4'd8:    r = 34'd2147483648;
         4'd9:    r = 34'd1908874354;
         4'd10:   r = 34'd1717986919;
         4'd11:   r = 34'd1561806290;
         4'd12:   r = 34'd1431655766;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sat16(input logic signed [R_W-1:0] v);
      logic [15:0] r;
      r = v[15:0];
      if (v > R_W'(signed'(32767))) r = 16'h7FFF;
      else if (v < -R_W'(signed'(32768))) r = 16'h8000;
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/dlfa_ram.sv
`default_nettype none
module dlfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: sv/dlfa_cell.sv
`default_nettype none
module dlfa_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift,
   input  wire logic                        clear,
   input  wire logic [dlfa_pkg::SUM_W-1:0]  d,
   output logic      [dlfa_pkg::SUM_W-1:0]  q
);
   logic [dlfa_pkg::SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      sum_in = sum_ff;
      if (clear) sum_in = '0;
      else if (shift) sum_in = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign q = sum_ff;
endmodule
`default_nettype wire

// File: sv/dlfa_div.sv
`default_nettype none
module dlfa_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [dlfa_pkg::NUM_W-1:0]  num,
   input  wire logic [dlfa_pkg::DEN_W-1:0]  den,
   output logic                             done,
   output logic      [dlfa_pkg::NUM_W-1:0]  quo
);
   logic [dlfa_pkg::NUM_W-1:0] work_ff, work_in;
   logic [dlfa_pkg::DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [dlfa_pkg::DEN_W:0]   rem_sh;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[dlfa_pkg::NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = 6'(dlfa_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? dlfa_pkg::DEN_W'(rem_sh - {1'b0, den_ff})
                      : rem_sh[dlfa_pkg::DEN_W-1:0];
         work_in = {work_ff[dlfa_pkg::NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quo  = work_ff;
endmodule
`default_nettype wire

// File: sv/dense_layer_forward_activation_top.sv
// Weight and bias load words are written straight into their memories while the block is idle.
// Activation word: a 64-step walk of the accumulator ring fed by the weight memory.
// Final input adds a pass per neuron: identity/relu go straight to the result; sigmoid/tanh
// evaluate twelve series terms (skipped for out-of-range inputs), then one 44-step serial divide.
// Softmax makes three ring passes (max, exp total, output).
// Synchronous reset clears control, registers to 64/64/0 and accumulators; memories undefined.
`default_nettype none
module dense_layer_forward_activation_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [5:0]         req_neuron_index,
   input  wire logic [5:0]         req_input_index,
   input  wire logic signed [15:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [5:0]              rsp_out_neuron,
   output logic signed [15:0]      rsp_activation_out,
   output logic                    rsp_last,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [6:0]         csr_wdata
);
   localparam int SW = dlfa_pkg::SUM_W;
   localparam int ZW = dlfa_pkg::Z_W;
   localparam int UW = dlfa_pkg::U_W;

   dlfa_pkg::state_type state_ff, state_in;
   dlfa_pkg::pass_type  pass_ff, pass_in;
   logic [6:0]  in_cnt_ff, in_cnt_in, nr_cnt_ff, nr_cnt_in;
   logic [2:0]  kind_ff, kind_in;
   logic [6:0]  n_ff, n_in, rd_ff, rd_in;
   logic        rv_ff, rv_in, pv_ff, pv_in, fin_ff, fin_in;
   logic [5:0]  rn_ff, rn_in, pn_ff, pn_in, ii_ff, ii_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [15:0] v_ff, v_in;
   logic signed [ZW-1:0] z_ff, z_in, zmax_ff, zmax_in;
   logic [UW-1:0] u_ff, u_in;
   logic [35:0] y_ff, y_in;
   logic [29:0] x_ff, x_in;
   logic [5:0]  k_ff, k_in;
   logic [30:0] term_ff, term_in, p_ff, p_in, e_ff, e_in, tq_ff, tq_in;
   logic signed [31:0] esum_ff, esum_in;
   logic [3:0]  i_ff, i_in;
   logic [47:0] total_ff, total_in;
   logic signed [dlfa_pkg::R_W-1:0] r_ff, r_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [5:0]  rsp_n_ff, rsp_n_in;
   logic [15:0] rsp_a_ff, rsp_a_in;

   logic        acc, shift, clear;
   logic [SW-1:0] ring_feed;
   logic [SW-1:0] cell_q [dlfa_pkg::NEURONS];
   logic [6:0]  nin, nn;
   logic [15:0] w_rdata, b_rdata;
   logic        div_start, div_done;
   logic [dlfa_pkg::NUM_W-1:0] div_num, div_quo;
   logic [dlfa_pkg::DEN_W-1:0] div_den, den_e;
   logic signed [40:0] s41;
   logic signed [41:0] t42;
   logic [UW-1:0] mag, zdiff;
   logic [47:0] ym;
   logic [59:0] xm;
   logic [60:0] pm;
   logic [63:0] qm;

   assign acc = req_valid && req_ready;
   assign nin = dlfa_pkg::eff_count(in_cnt_ff);
   assign nn  = dlfa_pkg::eff_count(nr_cnt_ff);

   dlfa_ram #(.WIDTH(16), .DEPTH(4096)) u_wram (
      .clock(clock),
      .we(acc && req_mode == dlfa_pkg::MODE_WEIGHT),
      .waddr({req_neuron_index, req_input_index}),
      .wdata(req_value),
      .raddr({rd_ff[5:0], ii_ff}),
      .rdata(w_rdata)
   );

   dlfa_ram #(.WIDTH(16), .DEPTH(64)) u_bram (
      .clock(clock),
      .we(acc && req_mode == dlfa_pkg::MODE_BIAS),
      .waddr(req_neuron_index),
      .wdata(req_value),
      .raddr(n_ff[5:0]),
      .rdata(b_rdata)
   );

   for (genvar g = 0; g < dlfa_pkg::NEURONS; g++) begin : g_ring
      if (g == dlfa_pkg::NEURONS - 1) begin : g_tail
         dlfa_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .clear(clear),
                           .d(ring_feed), .q(cell_q[g]));
      end else begin : g_body
         dlfa_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .clear(clear),
                           .d(cell_q[g+1]), .q(cell_q[g]));
      end
   end

   dlfa_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo)
   );

   always_comb begin
      s41   = 41'(signed'(cell_q[0])) + 41'(prod_ff);
      t42   = 42'(signed'(cell_q[0])) + (42'(signed'(b_rdata)) <<< dlfa_pkg::FRAC)
              + 42'(1 << (dlfa_pkg::FRAC - 1));
      mag   = z_ff[ZW-1] ? UW'(-(UW'(z_ff))) : UW'(z_ff);
      zdiff = UW'(UW'(zmax_ff) - UW'(z_ff));
      ym    = 48'(u_ff[16:0]) * 48'(dlfa_pkg::LOG2E_Q30);
      xm    = 60'(y_ff[29:0]) * 60'(dlfa_pkg::LN2_Q30);
      pm    = 61'(term_ff) * 61'(x_ff);
      qm    = 64'(p_ff[29:0]) * 64'(dlfa_pkg::term_recip(i_ff));
      den_e = 48'(dlfa_pkg::Q30_ONE) + 48'(e_ff);

      state_in = state_ff;  pass_in = pass_ff;
      in_cnt_in = in_cnt_ff; nr_cnt_in = nr_cnt_ff; kind_in = kind_ff;
      n_in = n_ff; rd_in = rd_ff; rv_in = 1'b0; pv_in = 1'b0; fin_in = fin_ff;
      rn_in = rn_ff; pn_in = pn_ff; ii_in = ii_ff; prod_in = prod_ff; v_in = v_ff;
      z_in = z_ff; zmax_in = zmax_ff; u_in = u_ff; y_in = y_ff; x_in = x_ff; k_in = k_ff;
      term_in = term_ff; p_in = p_ff; e_in = e_ff; esum_in = esum_ff; i_in = i_ff;
      tq_in = tq_ff;
      total_in = total_ff; r_in = r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_last_in = rsp_last_ff; rsp_n_in = rsp_n_ff; rsp_a_in = rsp_a_ff;
      shift = 1'b0; clear = 1'b0; ring_feed = cell_q[0];
      div_start = 1'b0; div_num = '0; div_den = '0;

      if (csr_we) begin
         case (csr_index)
            dlfa_pkg::CSR_INPUT_COUNT:  in_cnt_in = csr_wdata;
            dlfa_pkg::CSR_NEURON_COUNT: nr_cnt_in = csr_wdata;
            dlfa_pkg::CSR_ACT_KIND:     kind_in = csr_wdata[2:0];
            default: ;
         endcase
      end

      case (state_ff)
         dlfa_pkg::ST_IDLE: begin
            if (acc && req_mode == dlfa_pkg::MODE_ACT && {1'b0, req_input_index} < nin) begin
               ii_in    = req_input_index;
               v_in     = req_value;
               fin_in   = {1'b0, req_input_index} == nin - 7'd1;
               rd_in    = '0;
               state_in = dlfa_pkg::ST_MAC;
            end
         end
         dlfa_pkg::ST_MAC: begin
            if (!rd_ff[6]) begin
               rv_in = 1'b1;
               rn_in = rd_ff[5:0];
               rd_in = rd_ff + 7'd1;
            end
            pv_in   = rv_ff;
            pn_in   = rn_ff;
            prod_in = 32'(signed'(w_rdata)) * 32'(v_ff);
            if (pv_ff) begin
               shift = 1'b1;
               if ({1'b0, pn_ff} < nn) begin
                  if (s41[40] != s41[39]) ring_feed = s41[40] ? {1'b1, {(SW-1){1'b0}}}
                                                              : {1'b0, {(SW-1){1'b1}}};
                  else ring_feed = s41[SW-1:0];
               end
               if (pn_ff == 6'(dlfa_pkg::NEURONS - 1)) begin
                  n_in     = '0;
                  pass_in  = (kind_ff == dlfa_pkg::KIND_SOFTMAX) ? dlfa_pkg::PASS_MAX
                                                                 : dlfa_pkg::PASS_OUT;
                  state_in = fin_ff ? dlfa_pkg::ST_BIAS : dlfa_pkg::ST_IDLE;
               end
            end
         end
         dlfa_pkg::ST_BIAS: begin
            if (n_ff[6]) begin
               n_in    = '0;
               pass_in = (pass_ff == dlfa_pkg::PASS_MAX) ? dlfa_pkg::PASS_SUM
                                                         : dlfa_pkg::PASS_OUT;
            end else if (n_ff < nn) begin
               state_in = dlfa_pkg::ST_ZCALC;
            end else begin
               shift = 1'b1;
               n_in  = n_ff + 7'd1;
            end
         end
         dlfa_pkg::ST_ZCALC: begin
            z_in     = ZW'(t42 >>> dlfa_pkg::FRAC);
            state_in = dlfa_pkg::ST_ACT;
         end
         dlfa_pkg::ST_ACT: begin
            case (pass_ff)
               dlfa_pkg::PASS_MAX: begin
                  if (n_ff == 7'd0 || z_ff > zmax_ff) zmax_in = z_ff;
                  shift    = 1'b1;
                  n_in     = n_ff + 7'd1;
                  state_in = dlfa_pkg::ST_BIAS;
               end
               dlfa_pkg::PASS_SUM: begin
                  u_in     = zdiff;
                  state_in = dlfa_pkg::ST_EXP0;
               end
               default: begin
                  state_in = dlfa_pkg::ST_EXP0;
                  case (kind_ff)
                     dlfa_pkg::KIND_SIGMOID: u_in = mag;
                     dlfa_pkg::KIND_TANH:    u_in = UW'(mag << 1);
                     dlfa_pkg::KIND_SOFTMAX: u_in = zdiff;
                     dlfa_pkg::KIND_RELU: begin
                        r_in     = z_ff > 0 ? dlfa_pkg::R_W'(z_ff) : '0;
                        state_in = dlfa_pkg::ST_RESULT;
                     end
                     default: begin
                        r_in     = dlfa_pkg::R_W'(z_ff);
                        state_in = dlfa_pkg::ST_RESULT;
                     end
                  endcase
               end
            endcase
         end
         dlfa_pkg::ST_EXP0: begin
            if (u_ff >= dlfa_pkg::EXP_LIMIT) begin
               e_in     = '0;
               state_in = dlfa_pkg::ST_POST;
            end else begin
               y_in     = ym[47:12];
               state_in = dlfa_pkg::ST_EXP1;
            end
         end
         dlfa_pkg::ST_EXP1: begin
            x_in     = xm[59:30];
            k_in     = y_ff[35:30];
            term_in  = dlfa_pkg::Q30_ONE;
            esum_in  = 32'(dlfa_pkg::Q30_ONE);
            i_in     = 4'd1;
            state_in = dlfa_pkg::ST_TERM;
         end
         dlfa_pkg::ST_TERM: begin
            p_in     = pm[60:30];
            state_in = dlfa_pkg::ST_TSTART;
         end
         dlfa_pkg::ST_TSTART: begin
            tq_in    = (i_ff == 4'd1) ? 31'(p_ff[29:0]) : 31'(qm[63:34]);
            state_in = dlfa_pkg::ST_TWAIT;
         end
         dlfa_pkg::ST_TWAIT: begin
            term_in = tq_ff;
            esum_in = i_ff[0] ? esum_ff - 32'(tq_ff) : esum_ff + 32'(tq_ff);
            if (i_ff == 4'(dlfa_pkg::TERMS)) begin
               state_in = dlfa_pkg::ST_EXPEND;
            end else begin
               i_in     = i_ff + 4'd1;
               state_in = dlfa_pkg::ST_TERM;
            end
         end
         dlfa_pkg::ST_EXPEND: begin
            e_in     = 31'($unsigned(esum_ff) >> k_ff);
            state_in = dlfa_pkg::ST_POST;
         end
         dlfa_pkg::ST_POST: begin
            if (pass_ff == dlfa_pkg::PASS_SUM) begin
               total_in = total_ff + 48'(e_ff);
               shift    = 1'b1;
               n_in     = n_ff + 7'd1;
               state_in = dlfa_pkg::ST_BIAS;
            end else begin
               state_in = dlfa_pkg::ST_AWAIT;
               case (kind_ff)
                  dlfa_pkg::KIND_SIGMOID: begin
                     div_start = 1'b1;
                     div_den   = den_e;
                     div_num   = (z_ff[ZW-1] ? (44'(e_ff) << dlfa_pkg::FRAC)
                                             : (44'(dlfa_pkg::Q30_ONE) << dlfa_pkg::FRAC))
                                 + 44'(den_e >> 1);
                  end
                  dlfa_pkg::KIND_TANH: begin
                     div_start = 1'b1;
                     div_den   = den_e;
                     div_num   = (44'(dlfa_pkg::Q30_ONE - e_ff) << dlfa_pkg::FRAC)
                                 + 44'(den_e >> 1);
                  end
                  default: begin
                     if (total_ff == '0) begin
                        r_in     = '0;
                        state_in = dlfa_pkg::ST_RESULT;
                     end else begin
                        div_start = 1'b1;
                        div_den   = total_ff;
                        div_num   = (44'(e_ff) << dlfa_pkg::FRAC) + 44'(total_ff >> 1);
                     end
                  end
               endcase
            end
         end
         dlfa_pkg::ST_AWAIT: begin
            if (div_done) begin
               r_in = dlfa_pkg::R_W'(div_quo);
               if (kind_ff == dlfa_pkg::KIND_TANH && z_ff[ZW-1])
                  r_in = -dlfa_pkg::R_W'(div_quo);
               state_in = dlfa_pkg::ST_RESULT;
            end
         end
         dlfa_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_n_in     = n_ff[5:0];
               rsp_a_in     = dlfa_pkg::sat16(r_ff);
               rsp_last_in  = n_ff == nn - 7'd1;
               shift        = 1'b1;
               n_in         = n_ff + 7'd1;
               state_in     = (n_ff == nn - 7'd1) ? dlfa_pkg::ST_CLEAR : dlfa_pkg::ST_BIAS;
            end
         end
         dlfa_pkg::ST_CLEAR: begin
            clear    = 1'b1;
            total_in = '0;
            state_in = dlfa_pkg::ST_IDLE;
         end
         default: state_in = dlfa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlfa_pkg::ST_IDLE;
         pass_ff      <= dlfa_pkg::PASS_OUT;
         in_cnt_ff    <= 7'(dlfa_pkg::NEURONS);
         nr_cnt_ff    <= 7'(dlfa_pkg::NEURONS);
         kind_ff      <= dlfa_pkg::KIND_IDENTITY;
         n_ff         <= '0;
         rd_ff        <= '0;
         rv_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         fin_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         in_cnt_ff    <= in_cnt_in;
         nr_cnt_ff    <= nr_cnt_in;
         kind_ff      <= kind_in;
         n_ff         <= n_in;
         rd_ff        <= rd_in;
         rv_ff        <= rv_in;
         pv_ff        <= pv_in;
         fin_ff       <= fin_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rn_ff    <= rn_in;
      pn_ff    <= pn_in;
      ii_ff    <= ii_in;
      prod_ff  <= prod_in;
      v_ff     <= v_in;
      z_ff     <= z_in;
      zmax_ff  <= zmax_in;
      u_ff     <= u_in;
      y_ff     <= y_in;
      x_ff     <= x_in;
      k_ff     <= k_in;
      term_ff  <= term_in;
      p_ff     <= p_in;
      tq_ff    <= tq_in;
      e_ff     <= e_in;
      esum_ff  <= esum_in;
      i_ff     <= i_in;
      r_ff     <= r_in;
      rsp_n_ff <= rsp_n_in;
      rsp_a_ff <= rsp_a_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready          = state_ff == dlfa_pkg::ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_neuron     = rsp_n_ff;
   assign rsp_activation_out = rsp_a_ff;
   assign rsp_last           = rsp_last_ff;
endmodule
`default_nettype wire

// File: sv/dlfa_check.sv
`default_nettype none
module dlfa_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_mode,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  rsp_out_neuron,
   input wire logic [15:0] rsp_activation_out,
   input wire logic        rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result word dropped");

   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_activation_out) && $stable(rsp_out_neuron)
                                   && $stable(rsp_last)) else $error("result word changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready) else $error("bad state after reset");

   a_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != dlfa_pkg::MODE_ACT |=> req_ready)
      else $error("load word stalled input");

   a_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input taken mid-run");
endmodule

bind dense_layer_forward_activation_top dlfa_check u_dlfa_check (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_mode(req_mode), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_neuron(rsp_out_neuron), .rsp_activation_out(rsp_activation_out),
   .rsp_last(rsp_last)
);
`default_nettype wire
